// ----- src/iocdir_pkg.sv -----
// ----------------------------------------------------------------------------
// I/O channel register front end - shared definitions
// Field widths, transfer and control codes and the item structs of the
// input and result channels.
// ----------------------------------------------------------------------------
package iocdir_pkg;

    // Default number of subchannels
    localparam int SUBCHANNELS_DEF = 16;

    // Fixed field widths
    localparam int DATA_W  = 36;
    localparam int NUM_W   = 4;
    localparam int MASK_W  = 16;
    localparam int XFER_W  = 4;
    localparam int CTRL_W  = 2;
    localparam int APB_DW  = 32;
    localparam int APB_AW  = 3;

    // Command kinds
    localparam logic CMD_BUS  = 1'b0;
    localparam logic CMD_DONE = 1'b1;

    // Bus transfer kinds
    localparam logic [XFER_W-1:0] XFER_SELECT = 4'd1;
    localparam logic [XFER_W-1:0] XFER_WRITE  = 4'd3;
    localparam logic [XFER_W-1:0] XFER_POP    = 4'd8;
    localparam logic [XFER_W-1:0] XFER_STATUS = 4'd14;

    // Bus control kinds
    localparam logic [CTRL_W-1:0] CTRL_START = 2'd1;
    localparam logic [CTRL_W-1:0] CTRL_CLEAR = 2'd2;

    // Register byte addresses
    localparam logic [APB_AW-1:0] ADDR_ATTACHED = 3'd0;

    // Input item
    typedef struct packed {
        logic              command;
        logic [XFER_W-1:0] transfer_code;
        logic [CTRL_W-1:0] control_code;
        logic [DATA_W-1:0] bus_data;
        logic [NUM_W-1:0]  finished_subchannel;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              irq_level;
        logic              start_strobe;
        logic [NUM_W-1:0]  start_subchannel;
        logic [DATA_W-1:0] start_address_word;
    } t_out_item;

    // Lowest done subchannel
    typedef struct packed {
        logic             found;
        logic [NUM_W-1:0] num;
    } t_lowest;

endpackage

// ----- src/iocdir_lowest_done.sv -----
// ----------------------------------------------------------------------------
// Lowest done subchannel encoder
// Priority encoder over the done bits: reports whether any is set and the
// number of the lowest one.
// ----------------------------------------------------------------------------
module iocdir_lowest_done #(
    parameter int SUBCHANNELS = iocdir_pkg::SUBCHANNELS_DEF
) (
    input  logic [SUBCHANNELS-1:0] i_done,
    output iocdir_pkg::t_lowest    o_lowest
);

    // Scan from the top so the lowest set bit wins
    always_comb begin
        o_lowest.found = 1'b0;
        o_lowest.num   = '0;
        for (int i = SUBCHANNELS - 1; i >= 0; i--) begin
            if (i_done[i]) begin
                o_lowest.found = 1'b1;
                o_lowest.num   = iocdir_pkg::NUM_W'(i);
            end
        end
    end

endmodule

// ----- src/io_channel_done_interrupt_regs_unit.sv -----
// ----------------------------------------------------------------------------
// I/O channel register front end
// Subchannel select, channel address words, busy and done bits and the
// interrupt line of a multi-subchannel I/O channel.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_item) carries bus accesses
//   and subchannel completion events. Each item yields exactly one
//   result on the output channel (o_out_valid / i_out_ready / o_out_item):
//   pop data, the interrupt level after the item, and start information.
//   The APB port holds the attached-device mask at byte address 0; write it
//   only while the block is idle.
//   Flow: an item is captured in the input register, processed
//   combinationally from there and its result is loaded into the output
//   register, from which the receiver takes it. Throughput is one item per
//   cycle while the receiver does not stall; the state update and the
//   done-bit priority encoder are combinational, so consecutive items never
//   wait on each other.
//   When the receiver stalls, the result is held in the output register and
//   one more item may still be taken into the input register; after that
//   o_in_ready drops until the result is taken.
//   Synchronous reset clears selection, address words, busy and done bits,
//   the attached mask and both pipeline valid flags.
// ----------------------------------------------------------------------------
module io_channel_done_interrupt_regs_unit #(
    parameter int SUBCHANNELS = iocdir_pkg::SUBCHANNELS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  iocdir_pkg::t_in_item          i_in_item,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output iocdir_pkg::t_out_item         o_out_item,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [iocdir_pkg::APB_AW-1:0] paddr,
    input  logic [iocdir_pkg::APB_DW-1:0] pwdata,
    output logic [iocdir_pkg::APB_DW-1:0] prdata,
    output logic                          pready
);

    localparam int IDX_W  = $clog2(SUBCHANNELS);
    localparam int NUM_W  = iocdir_pkg::NUM_W;
    localparam int DATA_W = iocdir_pkg::DATA_W;
    localparam int MASK_W = iocdir_pkg::MASK_W;

    // Pipeline registers
    logic                  r_in_valid;
    iocdir_pkg::t_in_item  r_in;
    logic                  r_out_valid;
    iocdir_pkg::t_out_item r_out;

    // Channel state
    logic [MASK_W-1:0]      r_attached;
    logic [NUM_W-1:0]       r_sel;
    logic [DATA_W-1:0]      r_words [SUBCHANNELS];
    logic [SUBCHANNELS-1:0] r_done;
    logic [SUBCHANNELS-1:0] r_busy;

    // Next state
    logic [NUM_W-1:0]       n_sel;
    logic [SUBCHANNELS-1:0] n_done;
    logic [SUBCHANNELS-1:0] n_busy;
    logic                   n_word_we;
    iocdir_pkg::t_out_item  n_out;

    logic                 advance;
    iocdir_pkg::t_lowest  lowest;
    logic                 sel_live;
    logic                 wr_live;
    logic                 fin_live;
    logic [IDX_W-1:0]     sel_idx;
    logic [IDX_W-1:0]     wr_idx;
    logic [IDX_W-1:0]     fin_idx;
    logic                 cfg_wr;

    // Handshake: process when the result slot is free or being emptied
    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == iocdir_pkg::ADDR_ATTACHED);
    assign prdata = (paddr == iocdir_pkg::ADDR_ATTACHED) ?
                    iocdir_pkg::APB_DW'(r_attached) : '0;

    // Lowest done subchannel from the current done bits
    iocdir_lowest_done #(
        .SUBCHANNELS (SUBCHANNELS)
    ) u_lowest (
        .i_done   (r_done),
        .o_lowest (lowest)
    );

    // Subchannel numbers that address real subchannels
    assign wr_live  = ({1'b0, r_sel} < (NUM_W + 1)'(SUBCHANNELS));
    assign wr_idx   = r_sel[IDX_W-1:0];
    assign fin_live = ({1'b0, r_in.finished_subchannel} < (NUM_W + 1)'(SUBCHANNELS));
    assign fin_idx  = r_in.finished_subchannel[IDX_W-1:0];

    // Work out the effect of one item
    always_comb begin
        n_sel     = r_sel;
        n_done    = r_done;
        n_busy    = r_busy;
        n_word_we = 1'b0;
        n_out     = '0;
        sel_live  = 1'b0;
        sel_idx   = '0;

        if (r_in.command == iocdir_pkg::CMD_DONE) begin
            // completion: mark idle and done
            if (fin_live) begin
                n_busy[fin_idx] = 1'b0;
                n_done[fin_idx] = 1'b1;
            end
        end else begin
            // transfer part
            if (r_in.transfer_code == iocdir_pkg::XFER_SELECT) begin
                n_sel = r_in.bus_data[NUM_W-1:0];
            end else if (r_in.transfer_code == iocdir_pkg::XFER_WRITE) begin
                n_word_we = wr_live;
            end else if (r_in.transfer_code == iocdir_pkg::XFER_POP) begin
                if (lowest.found) begin
                    n_sel           = lowest.num;
                    n_out.read_data = DATA_W'(lowest.num);
                end else begin
                    n_out.read_data = '1;
                end
            end

            // selection left by the transfer
            sel_live = ({1'b0, n_sel} < (NUM_W + 1)'(SUBCHANNELS));
            sel_idx  = n_sel[IDX_W-1:0];

            // control part, on the selection after the transfer
            if (r_in.transfer_code != iocdir_pkg::XFER_STATUS && sel_live) begin
                if (r_in.control_code == iocdir_pkg::CTRL_START) begin
                    if (r_attached[sel_idx] && !r_busy[sel_idx]) begin
                        n_busy[sel_idx]          = 1'b1;
                        n_done[sel_idx]          = 1'b0;
                        n_out.start_strobe       = 1'b1;
                        n_out.start_subchannel   = n_sel;
                        n_out.start_address_word = n_word_we ? r_in.bus_data
                                                             : r_words[sel_idx];
                    end
                end else if (r_in.control_code == iocdir_pkg::CTRL_CLEAR) begin
                    n_done[sel_idx] = 1'b0;
                end
            end
        end

        n_out.irq_level = |n_done;
    end

    // Control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_attached  <= '0;
            r_sel       <= '0;
            r_done      <= '0;
            r_busy      <= '0;
            for (int i = 0; i < SUBCHANNELS; i++) begin
                r_words[i] <= '0;
            end
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_wr) begin
                r_attached <= pwdata[MASK_W-1:0];
            end
            if (advance) begin
                r_sel  <= n_sel;
                r_done <= n_done;
                r_busy <= n_busy;
                if (n_word_we) begin
                    r_words[wr_idx] <= r_in.bus_data;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_item;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

endmodule
